### hw/rtl/deque_pkg.sv
// Shared types and constants for the double-ended queue block.
// Used by deque_ctrl, deque_dp and double_ended_queue_top; depends on nothing.
package deque_pkg;

   // Default ring depth and fixed field widths
   localparam int unsigned DEPTH_DEFAULT = 16;
   localparam int unsigned VALUE_W       = 32;
   localparam int unsigned KIND_W        = 3;
   localparam int unsigned STATUS_W      = 2;
   localparam int unsigned OCC_W         = 5;
   localparam int unsigned REQ_DATA_W    = 32;
   localparam int unsigned RSP_DATA_W    = 40;

   // Request kinds
   localparam logic [KIND_W-1:0] KIND_PUSH_FRONT  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_PUSH_REAR   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_POP_REAR    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_POP_FRONT   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DRAIN_REAR  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_DRAIN_FRONT = 3'd5;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // Datapath operations, one per cycle
   typedef enum logic [3:0] {
      DP_NONE,
      DP_PUSH_FRONT,
      DP_PUSH_REAR,
      DP_FULL,
      DP_EMPTY,
      DP_NOOP,
      DP_POP_REAR,
      DP_POP_FRONT,
      DP_POP_LOAD,
      DP_DRAIN_REAR,
      DP_DRAIN_FRONT,
      DP_DRAIN_STEP
   } dp_op_type;

   // Controller to datapath
   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic empty;
      logic full;
      logic last_one;
   } dp_status_type;

endpackage

### hw/rtl/deque_dp.sv
// Datapath of the double-ended queue: ring store, head and count registers,
// drain pointer and the response holding register. Uses deque_pkg.
module deque_dp #(
   parameter int unsigned DEPTH = deque_pkg::DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  deque_pkg::dp_cmd_type                 cmd,
   output deque_pkg::dp_status_type              status,
   input  logic [deque_pkg::VALUE_W-1:0]         value_in,
   output logic [deque_pkg::VALUE_W-1:0]         value_out,
   output logic [deque_pkg::STATUS_W-1:0]        status_out,
   output logic [deque_pkg::OCC_W-1:0]           occupancy,
   output logic                                  last
);

   localparam int unsigned PW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned SW = CW + 1;
   localparam logic [PW-1:0] PTR_MAX   = PW'(DEPTH - 1);
   localparam logic [CW-1:0] CNT_FULL  = CW'(DEPTH);
   localparam logic [CW-1:0] CNT_ONE   = CW'(1);
   localparam logic [SW-1:0] SUM_DEPTH = SW'(DEPTH);

   // Ring store
   logic [deque_pkg::VALUE_W-1:0] mem [DEPTH];
   logic [deque_pkg::VALUE_W-1:0] rdata_ff;

   logic [PW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [PW-1:0] dptr_ff, dptr_in;
   logic          drain_rear_ff, drain_rear_in;

   logic [deque_pkg::VALUE_W-1:0]  value_out_ff, value_out_in;
   logic [deque_pkg::STATUS_W-1:0] status_out_ff, status_out_in;
   logic [deque_pkg::OCC_W-1:0]    occ_ff, occ_in;
   logic                           last_ff, last_in;

   logic          wr_en, rd_en;
   logic [PW-1:0] wr_addr, rd_addr;

   logic [PW-1:0] head_inc, head_dec, dptr_next;
   logic [SW-1:0] tail_sum, rear_sum;
   logic [PW-1:0] tail_pos, rear_pos;
   logic [CW-1:0] count_dec, count_inc;

   // Ring arithmetic: head +/- 1, free slot after rear, rear element
   always_comb begin
      head_inc  = (head_ff == PTR_MAX) ? '0 : head_ff + PW'(1);
      head_dec  = (head_ff == '0) ? PTR_MAX : head_ff - PW'(1);
      count_dec = count_ff - CNT_ONE;
      count_inc = count_ff + CNT_ONE;
      tail_sum  = SW'(head_ff) + SW'(count_ff);
      tail_pos  = (tail_sum >= SUM_DEPTH) ? PW'(tail_sum - SUM_DEPTH) : PW'(tail_sum);
      rear_sum  = tail_sum - SW'(1);
      rear_pos  = (rear_sum >= SUM_DEPTH) ? PW'(rear_sum - SUM_DEPTH) : PW'(rear_sum);
      if (drain_rear_ff) begin
         dptr_next = (dptr_ff == '0) ? PTR_MAX : dptr_ff - PW'(1);
      end else begin
         dptr_next = (dptr_ff == PTR_MAX) ? '0 : dptr_ff + PW'(1);
      end
   end

   // Operation decode
   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      dptr_in       = dptr_ff;
      drain_rear_in = drain_rear_ff;
      value_out_in  = value_out_ff;
      status_out_in = status_out_ff;
      occ_in        = occ_ff;
      last_in       = last_ff;
      wr_en         = 1'b0;
      wr_addr       = tail_pos;
      rd_en         = 1'b0;
      rd_addr       = head_ff;
      unique case (cmd.op)
         deque_pkg::DP_PUSH_FRONT: begin
            wr_en         = 1'b1;
            wr_addr       = head_dec;
            head_in       = head_dec;
            count_in      = count_inc;
            value_out_in  = '0;
            status_out_in = deque_pkg::STATUS_OK;
            occ_in        = deque_pkg::OCC_W'(count_inc);
            last_in       = 1'b1;
         end
         deque_pkg::DP_PUSH_REAR: begin
            wr_en         = 1'b1;
            wr_addr       = tail_pos;
            count_in      = count_inc;
            value_out_in  = '0;
            status_out_in = deque_pkg::STATUS_OK;
            occ_in        = deque_pkg::OCC_W'(count_inc);
            last_in       = 1'b1;
         end
         deque_pkg::DP_FULL: begin
            value_out_in  = '0;
            status_out_in = deque_pkg::STATUS_FULL;
            occ_in        = deque_pkg::OCC_W'(count_ff);
            last_in       = 1'b1;
         end
         deque_pkg::DP_EMPTY: begin
            value_out_in  = '0;
            status_out_in = deque_pkg::STATUS_EMPTY;
            occ_in        = '0;
            last_in       = 1'b1;
         end
         deque_pkg::DP_NOOP: begin
            value_out_in  = '0;
            status_out_in = deque_pkg::STATUS_OK;
            occ_in        = deque_pkg::OCC_W'(count_ff);
            last_in       = 1'b1;
         end
         deque_pkg::DP_POP_REAR: begin
            rd_en    = 1'b1;
            rd_addr  = rear_pos;
            count_in = count_dec;
         end
         deque_pkg::DP_POP_FRONT: begin
            rd_en    = 1'b1;
            rd_addr  = head_ff;
            head_in  = head_inc;
            count_in = count_dec;
         end
         deque_pkg::DP_POP_LOAD: begin
            // count was already lowered when the read was issued
            value_out_in  = rdata_ff;
            status_out_in = deque_pkg::STATUS_OK;
            occ_in        = deque_pkg::OCC_W'(count_ff);
            last_in       = 1'b1;
         end
         deque_pkg::DP_DRAIN_REAR: begin
            rd_en         = 1'b1;
            rd_addr       = rear_pos;
            dptr_in       = rear_pos;
            drain_rear_in = 1'b1;
         end
         deque_pkg::DP_DRAIN_FRONT: begin
            rd_en         = 1'b1;
            rd_addr       = head_ff;
            dptr_in       = head_ff;
            drain_rear_in = 1'b0;
         end
         deque_pkg::DP_DRAIN_STEP: begin
            // emit current element and prefetch the next one
            value_out_in  = rdata_ff;
            status_out_in = deque_pkg::STATUS_OK;
            occ_in        = deque_pkg::OCC_W'(count_dec);
            last_in       = (count_ff == CNT_ONE);
            count_in      = count_dec;
            dptr_in       = dptr_next;
            rd_en         = 1'b1;
            rd_addr       = dptr_next;
         end
         default: begin
         end
      endcase
   end

   // Store write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= value_in;
      end
   end

   // Store read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      dptr_ff       <= dptr_in;
      drain_rear_ff <= drain_rear_in;
      value_out_ff  <= value_out_in;
      status_out_ff <= status_out_in;
      occ_ff        <= occ_in;
      last_ff       <= last_in;
   end

   assign status.empty    = (count_ff == '0);
   assign status.full     = (count_ff >= CNT_FULL);
   assign status.last_one = (count_ff == CNT_ONE);

   assign value_out  = value_out_ff;
   assign status_out = status_out_ff;
   assign occupancy  = occ_ff;
   assign last       = last_ff;

endmodule

### hw/rtl/deque_ctrl.sv
// Controller of the double-ended queue: request decode, pop and drain
// sequencing, response valid. Uses deque_pkg; drives deque_dp.
module deque_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [deque_pkg::KIND_W-1:0]     kind,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output deque_pkg::dp_cmd_type            cmd,
   input  deque_pkg::dp_status_type         status
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_POP,
      S_DRAIN
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      load;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;

   // Next state and datapath command
   always_comb begin
      state_in = state_ff;
      cmd.op   = deque_pkg::DP_NONE;
      load     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && out_free) begin
               unique case (kind)
                  deque_pkg::KIND_PUSH_FRONT: begin
                     cmd.op = status.full ? deque_pkg::DP_FULL : deque_pkg::DP_PUSH_FRONT;
                     load   = 1'b1;
                  end
                  deque_pkg::KIND_PUSH_REAR: begin
                     cmd.op = status.full ? deque_pkg::DP_FULL : deque_pkg::DP_PUSH_REAR;
                     load   = 1'b1;
                  end
                  deque_pkg::KIND_POP_REAR, deque_pkg::KIND_POP_FRONT: begin
                     if (status.empty) begin
                        cmd.op = deque_pkg::DP_EMPTY;
                        load   = 1'b1;
                     end else begin
                        cmd.op   = (kind == deque_pkg::KIND_POP_REAR) ?
                                   deque_pkg::DP_POP_REAR : deque_pkg::DP_POP_FRONT;
                        state_in = S_POP;
                     end
                  end
                  deque_pkg::KIND_DRAIN_REAR, deque_pkg::KIND_DRAIN_FRONT: begin
                     if (status.empty) begin
                        cmd.op = deque_pkg::DP_EMPTY;
                        load   = 1'b1;
                     end else begin
                        cmd.op   = (kind == deque_pkg::KIND_DRAIN_REAR) ?
                                   deque_pkg::DP_DRAIN_REAR : deque_pkg::DP_DRAIN_FRONT;
                        state_in = S_DRAIN;
                     end
                  end
                  default: begin
                     cmd.op = deque_pkg::DP_NOOP;
                     load   = 1'b1;
                  end
               endcase
            end
         end
         S_POP: begin
            // read data is ready; output register is free here
            cmd.op   = deque_pkg::DP_POP_LOAD;
            load     = 1'b1;
            state_in = S_IDLE;
         end
         S_DRAIN: begin
            if (out_free) begin
               cmd.op = deque_pkg::DP_DRAIN_STEP;
               load   = 1'b1;
               if (status.last_one) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Response valid
   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

### hw/rtl/double_ended_queue_top.sv
// Top level of the double-ended queue: stream ports around the controller
// and the datapath. Uses deque_pkg, deque_ctrl and deque_dp.
//
// Double-ended queue of signed 32-bit values in a ring store of DEPTH entries.
// Each request beat carries an operation in req_tuser and a value in req_tdata;
// every request gives one response beat, except a drain of a non-empty queue,
// which gives one beat per stored value with rsp_tlast on the final one. The
// responses sit in an output register. A push, a full or empty answer and an
// unused kind load it directly; a pop reads the ring store (registered read
// port), then loads it; a drain prefetches its first value, then emits each
// value while fetching the next. A new request is taken only after the
// previous one has finished and while the output register is empty or being emptied.
module double_ended_queue_top #(
   parameter int unsigned DEPTH = deque_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [deque_pkg::REQ_DATA_W-1:0]    req_tdata,  // [31:0] value_in
   input  logic [deque_pkg::KIND_W-1:0]        req_tuser,  // [2:0] kind
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [deque_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // [31:0] value_out,
                                                           // [36:32] occupancy, pad
   output logic [deque_pkg::STATUS_W-1:0]      rsp_tuser,  // [1:0] status
   output logic                                rsp_tlast
);

   deque_pkg::dp_cmd_type    cmd;
   deque_pkg::dp_status_type status;

   logic [deque_pkg::VALUE_W-1:0] value_out;
   logic [deque_pkg::OCC_W-1:0]   occupancy;

   deque_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .kind       (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   deque_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .value_in   (req_tdata),
      .value_out  (value_out),
      .status_out (rsp_tuser),
      .occupancy  (occupancy),
      .last       (rsp_tlast)
   );

   // Response beat packing
   assign rsp_tdata = {{(deque_pkg::RSP_DATA_W - deque_pkg::VALUE_W - deque_pkg::OCC_W){1'b0}},
                       occupancy, value_out};

endmodule
